// ===== design/ige_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ising grid energy evaluator package
// Shared widths, command codes, control structs and the index wrap table.
// ----------------------------------------------------------------------------
package ige_pkg;

    localparam int IGE_SIDE_DEF = 64;

    localparam int IN_IDX_W   = 6;
    localparam int IN_DATA_W  = 16;
    localparam int FIELD_W    = 16;
    localparam int DELTA_W    = 18;
    localparam int TOT_W      = 14;
    localparam int MAG_W      = 16;
    localparam int RATIO_W    = 16;
    localparam int OUT_DATA_W = 64;

    localparam int NSUM_W = 4;
    localparam int T_W    = 18;
    localparam int BH_W   = 19;
    localparam int NUM_W  = 33;
    localparam int DEN_W  = 28;
    localparam int DVD_W  = 44;
    localparam int DVS_W  = 27;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_FLIP   = 2'd2,
        CMD_TOTALS = 2'd3
    } cmd_e_t;

    typedef enum logic [1:0] {
        CUR_HOLD = 2'd0,
        CUR_LOAD = 2'd1,
        CUR_ZERO = 2'd2,
        CUR_NEXT = 2'd3
    } cur_op_t;

    typedef enum logic [2:0] {
        NB_C = 3'd0,
        NB_U = 3'd1,
        NB_D = 3'd2,
        NB_L = 3'd3,
        NB_R = 3'd4
    } nb_sel_t;

    typedef enum logic [1:0] {
        OP_NONE     = 2'd0,
        OP_LOAD_S   = 2'd1,
        OP_ADD_N    = 2'd2,
        OP_CELL_ACC = 2'd3
    } rd_op_t;

    typedef struct packed {
        cur_op_t cur_op;
        logic    acc_clear;
        nb_sel_t rd_sel;
        rd_op_t  rd_op;
        logic    wr_spin;
        logic    clr_wr;
        logic    calc1;
        logic    calc2;
        logic    div_start;
        logic    mag_cap;
        logic    out_load;
        cmd_e_t  out_kind;
    } ige_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic cur_last;
        logic div_done;
        logic div_busy;
        logic out_free;
    } ige_stat_t;

    typedef logic [7:0] mod_tab_t [64];

    function automatic mod_tab_t build_mod_tab(input int unsigned side);
        mod_tab_t    tab;
        int unsigned m;
        m = 0;
        for (int i = 0; i < 64; i++)
        begin
            tab[i] = 8'(m);
            m = m + 1;
            if (m == side)
            begin
                m = 0;
            end
        end
        return tab;
    endfunction

endpackage

// ===== design/ige_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ising grid energy evaluator divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ige_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ige_pkg::DVD_W-1:0]  dividend,
    input  logic [ige_pkg::DVS_W-1:0]  divisor,
    output logic                       busy,
    output logic                       done,
    output logic [ige_pkg::DVD_W-1:0]  quotient
);
    import ige_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/ige_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ising grid energy evaluator datapath
// Spin memory, neighbor addressing, accumulators, energy math and output.
// ----------------------------------------------------------------------------
module ige_datapath #(
    parameter int SIDE = ige_pkg::IGE_SIDE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [ige_pkg::FIELD_W-1:0]     cfg_wr_data,
    input  logic [ige_pkg::IN_IDX_W-1:0]    in_row,
    input  logic [ige_pkg::IN_IDX_W-1:0]    in_col,
    input  logic [1:0]                      in_spin,
    input  ige_pkg::ige_cmd_t               cmd,
    output ige_pkg::ige_stat_t              stat,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [ige_pkg::OUT_DATA_W-1:0]  out_data,
    output logic                            out_status
);
    import ige_pkg::*;

    localparam int CELLS  = SIDE * SIDE;
    localparam int IDX_W  = $clog2(SIDE);
    localparam int ADDR_W = $clog2(CELLS);
    localparam mod_tab_t MOD_TAB = build_mod_tab(SIDE);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(SIDE - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] ADDR_SIDE = ADDR_W'(SIDE);
    localparam logic signed [DEN_W-1:0] DEN_BASE = DEN_W'(1024 * CELLS);
    localparam int MAG_K = 2 * $clog2(CELLS) + 1;
    localparam logic [31:0] MAG_M =
        32'(((64'd1 << (14 + MAG_K)) + 64'(CELLS) - 64'd1) / 64'(CELLS));
    localparam logic signed [T_W-1:0] T_HI = T_W'(8191);
    localparam logic signed [T_W-1:0] T_LO = T_W'(-8192);
    localparam logic [RATIO_W-1:0] RATIO_MAX = 16'h7FFF;
    localparam logic [RATIO_W-1:0] RATIO_MIN = 16'h8000;

    logic [1:0] grid_mem [CELLS];

    logic signed [FIELD_W-1:0] field_reg;
    logic [IDX_W-1:0]          row_reg;
    logic [IDX_W-1:0]          col_reg;
    logic [1:0]                spin_reg;
    logic [ADDR_W-1:0]         clr_addr_reg;
    logic [1:0]                rdata_reg;
    rd_op_t                    op_reg;
    logic signed [1:0]         s_reg;
    logic signed [NSUM_W-1:0]  nsum_reg;
    logic signed [T_W-1:0]     t_reg;
    logic signed [BH_W-1:0]    bh_reg;
    logic signed [NUM_W-1:0]   prod_reg;
    logic signed [NUM_W-1:0]   num_reg;
    logic signed [DEN_W-1:0]   den_reg;
    logic signed [MAG_W-1:0]   mag_reg;
    logic                      out_valid_reg;
    logic [DELTA_W-1:0]        out_delta_reg;
    logic [TOT_W-1:0]          out_tot_reg;
    logic [MAG_W-1:0]          out_mag_reg;
    logic [RATIO_W-1:0]        out_ratio_reg;
    logic                      out_status_reg;

    logic [IDX_W-1:0]  row_up, row_dn, col_lf, col_rt, rd_row, rd_col;
    logic [ADDR_W-1:0] rd_addr, cur_addr, mem_waddr;
    logic              mem_we;
    logic [1:0]        mem_wdata;
    logic              s_pos, s_neg;
    logic signed [NSUM_W-1:0]  sn;
    logic signed [DELTA_W-1:0] delta_base, delta_val;
    logic signed [2*FIELD_W+1:0] prod_full;
    logic signed [DEN_W-1:0]     hs_full;
    logic [NUM_W-1:0]  num_abs;
    logic [T_W-1:0]    t_abs;
    logic [T_W+31:0]   mag_prod;
    logic [DVD_W-1:0]  div_dvd, div_q;
    logic [DVS_W-1:0]  div_dvs;
    logic              div_busy, div_done;
    logic [MAG_W-1:0]  q_mag;
    logic              den_pos, num_neg;
    logic [RATIO_W-1:0] ratio_val;
    logic              ratio_sat;
    logic [TOT_W-1:0]  tot_val;

    assign row_up = (row_reg == '0) ? IDX_LAST : row_reg - IDX_W'(1);
    assign row_dn = (row_reg == IDX_LAST) ? '0 : row_reg + IDX_W'(1);
    assign col_lf = (col_reg == '0) ? IDX_LAST : col_reg - IDX_W'(1);
    assign col_rt = (col_reg == IDX_LAST) ? '0 : col_reg + IDX_W'(1);

    always_comb
    begin
        rd_row = row_reg;
        rd_col = col_reg;
        case (cmd.rd_sel)
            NB_U:    rd_row = row_up;
            NB_D:    rd_row = row_dn;
            NB_L:    rd_col = col_lf;
            NB_R:    rd_col = col_rt;
            default: rd_row = row_reg;
        endcase
    end

    assign rd_addr  = ADDR_W'(ADDR_W'(rd_row) * ADDR_SIDE) + ADDR_W'(rd_col);
    assign cur_addr = ADDR_W'(ADDR_W'(row_reg) * ADDR_SIDE) + ADDR_W'(col_reg);

    assign mem_we    = cmd.clr_wr | cmd.wr_spin;
    assign mem_waddr = cmd.clr_wr ? clr_addr_reg : cur_addr;
    assign mem_wdata = cmd.clr_wr ? 2'b00 : spin_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= grid_mem[rd_addr];
    end

    assign s_pos = !s_reg[1] && s_reg[0];
    assign s_neg = s_reg[1];
    assign sn    = s_pos ? nsum_reg : (s_neg ? -nsum_reg : '0);

    assign delta_base = (DELTA_W'(nsum_reg) <<< 9) - (DELTA_W'(field_reg) <<< 1);
    assign delta_val  = s_pos ? delta_base : (s_neg ? -delta_base : '0);

    assign prod_full = field_reg * t_reg;
    assign hs_full   = DEN_W'(field_reg) * DEN_W'(SIDE);

    assign num_neg  = num_reg[NUM_W-1];
    assign num_abs  = num_neg ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign t_abs    = t_reg[T_W-1] ? T_W'(-t_reg) : T_W'(t_reg);
    assign mag_prod = t_abs * MAG_M;
    assign q_mag    = mag_prod[MAG_K +: MAG_W];
    assign div_dvd  = DVD_W'({num_abs, 12'b0});
    assign div_dvs  = den_reg[DVS_W-1:0];

    ige_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign den_pos = !den_reg[DEN_W-1] && (den_reg != '0);

    always_comb
    begin
        ratio_sat = 1'b0;
        ratio_val = div_q[RATIO_W-1:0];
        if (!den_pos)
        begin
            ratio_sat = 1'b1;
            if (num_reg == '0)
            begin
                ratio_val = '0;
            end
            else
            begin
                ratio_val = num_neg ? RATIO_MIN : RATIO_MAX;
            end
        end
        else if (!num_neg)
        begin
            if (div_q > DVD_W'(RATIO_MAX))
            begin
                ratio_sat = 1'b1;
                ratio_val = RATIO_MAX;
            end
        end
        else
        begin
            if (div_q > DVD_W'(17'h08000))
            begin
                ratio_sat = 1'b1;
                ratio_val = RATIO_MIN;
            end
            else
            begin
                ratio_val = -div_q[RATIO_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (t_reg > T_HI)
        begin
            tot_val = T_HI[TOT_W-1:0];
        end
        else if (t_reg < T_LO)
        begin
            tot_val = T_LO[TOT_W-1:0];
        end
        else
        begin
            tot_val = t_reg[TOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg     <= '0;
            clr_addr_reg  <= '0;
            op_reg        <= OP_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                field_reg <= cfg_wr_data;
            end
            if (cmd.clr_wr)
            begin
                clr_addr_reg <= (clr_addr_reg == ADDR_LAST) ? '0 : clr_addr_reg + ADDR_W'(1);
            end
            op_reg <= cmd.rd_op;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.cur_op)
            CUR_LOAD:
            begin
                row_reg  <= MOD_TAB[in_row][IDX_W-1:0];
                col_reg  <= MOD_TAB[in_col][IDX_W-1:0];
                spin_reg <= in_spin[1] ? 2'b11 : in_spin;
            end
            CUR_ZERO:
            begin
                row_reg <= '0;
                col_reg <= '0;
            end
            CUR_NEXT:
            begin
                if (col_reg == IDX_LAST)
                begin
                    col_reg <= '0;
                    row_reg <= row_dn;
                end
                else
                begin
                    col_reg <= col_rt;
                end
            end
            default:
            begin
                row_reg <= row_reg;
            end
        endcase

        case (op_reg)
            OP_LOAD_S:
            begin
                s_reg    <= rdata_reg;
                nsum_reg <= '0;
            end
            OP_ADD_N:
            begin
                nsum_reg <= nsum_reg + NSUM_W'($signed(rdata_reg));
            end
            OP_CELL_ACC:
            begin
                t_reg  <= t_reg + T_W'(s_reg);
                bh_reg <= bh_reg + BH_W'(sn);
            end
            default:
            begin
                s_reg <= s_reg;
            end
        endcase

        if (cmd.acc_clear)
        begin
            t_reg  <= '0;
            bh_reg <= '0;
        end
        if (cmd.calc1)
        begin
            prod_reg <= NUM_W'(prod_full);
            den_reg  <= DEN_BASE + hs_full;
        end
        if (cmd.calc2)
        begin
            num_reg <= prod_reg - (NUM_W'(bh_reg) <<< 9);
        end
        if (cmd.mag_cap)
        begin
            mag_reg <= t_reg[T_W-1] ? -q_mag : q_mag;
        end

        if (cmd.out_load)
        begin
            out_delta_reg  <= (cmd.out_kind == CMD_FLIP) ? delta_val : '0;
            out_tot_reg    <= (cmd.out_kind == CMD_TOTALS) ? tot_val : '0;
            out_mag_reg    <= (cmd.out_kind == CMD_TOTALS) ? mag_reg : '0;
            out_ratio_reg  <= (cmd.out_kind == CMD_TOTALS) ? ratio_val : '0;
            out_status_reg <= (cmd.out_kind == CMD_TOTALS) ? ratio_sat : 1'b0;
        end
    end

    assign stat.clr_last = (clr_addr_reg == ADDR_LAST);
    assign stat.cur_last = (row_reg == IDX_LAST) && (col_reg == IDX_LAST);
    assign stat.div_done = div_done;
    assign stat.div_busy = div_busy;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_data   = {out_ratio_reg, out_mag_reg, out_tot_reg, out_delta_reg};
    assign out_status = out_status_reg;

endmodule

// ===== design/ige_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ising grid energy evaluator controller
// Sequences memory reads, sweeps, divisions and result hand-off.
// ----------------------------------------------------------------------------
module ige_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  ige_pkg::cmd_e_t     in_cmd,
    output logic                in_ready,
    input  ige_pkg::ige_stat_t  stat,
    output ige_pkg::ige_cmd_t   cmd
);
    import ige_pkg::*;

    typedef enum logic [19:0] {
        S_RST_CLR  = 20'h00001,
        S_IDLE     = 20'h00002,
        S_WRITE    = 20'h00004,
        S_CLR      = 20'h00008,
        S_FC       = 20'h00010,
        S_FU       = 20'h00020,
        S_FD       = 20'h00040,
        S_FL       = 20'h00080,
        S_FR       = 20'h00100,
        S_FDRAIN   = 20'h00200,
        S_SC       = 20'h00400,
        S_SR       = 20'h00800,
        S_SD       = 20'h01000,
        S_SA       = 20'h02000,
        S_TDRAIN   = 20'h04000,
        S_CALC1    = 20'h08000,
        S_CALC2    = 20'h10000,
        S_RAT_GO   = 20'h20000,
        S_RAT_WAIT = 20'h40000,
        S_DONE     = 20'h80000
    } state_t;

    state_t  state_reg, state_next;
    cmd_e_t  kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RST_CLR;
            kind_reg  <= CMD_WRITE;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        cmd.cur_op    = CUR_HOLD;
        cmd.acc_clear = 1'b0;
        cmd.rd_sel    = NB_C;
        cmd.rd_op     = OP_NONE;
        cmd.wr_spin   = 1'b0;
        cmd.clr_wr    = 1'b0;
        cmd.calc1     = 1'b0;
        cmd.calc2     = 1'b0;
        cmd.div_start = 1'b0;
        cmd.mag_cap   = 1'b0;
        cmd.out_load  = 1'b0;
        cmd.out_kind  = kind_reg;
        case (state_reg)
            S_RST_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = in_cmd;
                    case (in_cmd)
                        CMD_WRITE:
                        begin
                            cmd.cur_op = CUR_LOAD;
                            state_next = S_WRITE;
                        end
                        CMD_CLEAR:
                        begin
                            state_next = S_CLR;
                        end
                        CMD_FLIP:
                        begin
                            cmd.cur_op = CUR_LOAD;
                            state_next = S_FC;
                        end
                        CMD_TOTALS:
                        begin
                            cmd.cur_op    = CUR_ZERO;
                            cmd.acc_clear = 1'b1;
                            state_next    = S_SC;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WRITE:
            begin
                cmd.wr_spin = 1'b1;
                state_next  = S_DONE;
            end
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_FC:
            begin
                cmd.rd_sel = NB_C;
                cmd.rd_op  = OP_LOAD_S;
                state_next = S_FU;
            end
            S_FU:
            begin
                cmd.rd_sel = NB_U;
                cmd.rd_op  = OP_ADD_N;
                state_next = S_FD;
            end
            S_FD:
            begin
                cmd.rd_sel = NB_D;
                cmd.rd_op  = OP_ADD_N;
                state_next = S_FL;
            end
            S_FL:
            begin
                cmd.rd_sel = NB_L;
                cmd.rd_op  = OP_ADD_N;
                state_next = S_FR;
            end
            S_FR:
            begin
                cmd.rd_sel = NB_R;
                cmd.rd_op  = OP_ADD_N;
                state_next = S_FDRAIN;
            end
            S_FDRAIN:
            begin
                state_next = S_DONE;
            end
            S_SC:
            begin
                cmd.rd_sel = NB_C;
                cmd.rd_op  = OP_LOAD_S;
                state_next = S_SR;
            end
            S_SR:
            begin
                cmd.rd_sel = NB_R;
                cmd.rd_op  = OP_ADD_N;
                state_next = S_SD;
            end
            S_SD:
            begin
                cmd.rd_sel = NB_D;
                cmd.rd_op  = OP_ADD_N;
                state_next = S_SA;
            end
            S_SA:
            begin
                cmd.rd_op  = OP_CELL_ACC;
                cmd.cur_op = CUR_NEXT;
                state_next = stat.cur_last ? S_TDRAIN : S_SC;
            end
            S_TDRAIN:
            begin
                state_next = S_CALC1;
            end
            S_CALC1:
            begin
                cmd.calc1   = 1'b1;
                cmd.mag_cap = 1'b1;
                state_next  = S_CALC2;
            end
            S_CALC2:
            begin
                cmd.calc2  = 1'b1;
                state_next = S_RAT_GO;
            end
            S_RAT_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_RAT_WAIT;
            end
            S_RAT_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/ising_grid_energy_evaluator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ising grid energy evaluator core
// Toroidal spin grid with flip energy and normalized total energy queries.
// ----------------------------------------------------------------------------
// Each request on the s_axis channel carries one command and produces exactly
// one result on the m_axis channel. The field strength is set through
// cfg_wr_en and cfg_wr_data; the user must write it only while the block is
// idle, as the block itself does not enforce this. A flip energy query
// makes five reads through the single memory read port. A grid clear
// writes one memory entry per cycle. A totals query makes three reads and
// one accumulate step per cell, then one division for the energy ratio.
// One request is in work at a time; s_axis_tready is high only when idle.
// After reset a clearing pass zeroes all SIDE*SIDE grid entries with
// s_axis_tready low; configuration writes are taken during that pass.
// A finished result waits in the output register while the next request is
// accepted; a request finishing while the receiver still stalls holds until
// the output register frees.
// ----------------------------------------------------------------------------
module ising_grid_energy_evaluator_core #(
    parameter int SIDE = ige_pkg::IGE_SIDE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [ige_pkg::FIELD_W-1:0]     cfg_wr_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: cmd[1:0], row[7:2], col[13:8], spin[15:14].
    input  logic [ige_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0: delta_energy[17:0], total_spin[31:18],
    // magnetisation[47:32], energy_ratio[63:48].
    output logic [ige_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // Fields from bit 0: status[0].
    output logic                            m_axis_tuser
);
    import ige_pkg::*;

    ige_cmd_t  ctl_cmd;
    ige_stat_t dp_stat;
    cmd_e_t    in_cmd;

    assign in_cmd = cmd_e_t'(s_axis_tdata[1:0]);

    ige_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_cmd   (in_cmd),
        .in_ready (s_axis_tready),
        .stat     (dp_stat),
        .cmd      (ctl_cmd)
    );

    ige_datapath #(
        .SIDE (SIDE)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_row      (s_axis_tdata[7:2]),
        .in_col      (s_axis_tdata[13:8]),
        .in_spin     (s_axis_tdata[15:14]),
        .cmd         (ctl_cmd),
        .stat        (dp_stat),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_data    (m_axis_tdata),
        .out_status  (m_axis_tuser)
    );

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over an unaccepted result");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !ctl_cmd.clr_wr)
        else $error("request ready during grid clear");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.div_start |-> !dp_stat.div_busy)
        else $error("divider started while busy");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ising grid energy evaluator testbench
// Drives spin writes, clears, flip energy and totals requests with random
// idling on both channels and checks every result against a spin grid model.
// ----------------------------------------------------------------------------
class ising_scoreboard;
    logic signed [1:0] grid [64][64];
    logic signed [15:0] field;
    logic [64:0] pending [$];
    int errors;

    function new();
        foreach (grid[i, j])
        begin
            grid[i][j] = 0;
        end
        field = 0;
        errors = 0;
    endfunction

    function int nsum(int r, int c);
        return grid[(r + 63) % 64][c] + grid[(r + 1) % 64][c]
            + grid[r][(c + 63) % 64] + grid[r][(c + 1) % 64];
    endfunction

    function void note_request(logic [15:0] d);
        ige_pkg::cmd_e_t cmd;
        int r;
        int c;
        int s;
        longint delta;
        longint t;
        longint b;
        longint tot;
        longint mag;
        longint num;
        longint den;
        longint q;
        longint ratio;
        logic st;
        cmd = ige_pkg::cmd_e_t'(d[1:0]);
        r = d[7:2];
        c = d[13:8];
        s = $signed(d[15:14]);
        if (s < -1)
        begin
            s = -1;
        end
        delta = 0;
        tot = 0;
        mag = 0;
        ratio = 0;
        st = 0;
        case (cmd)
            ige_pkg::CMD_WRITE: grid[r][c] = 2'(s);
            ige_pkg::CMD_CLEAR:
            begin
                foreach (grid[i, j])
                begin
                    grid[i][j] = 0;
                end
            end
            ige_pkg::CMD_FLIP:
            begin
                delta = 2 * grid[r][c] * nsum(r, c) * 256 - 2 * grid[r][c] * field;
            end
            default:
            begin
                t = 0;
                b = 0;
                foreach (grid[i, j])
                begin
                    t += grid[i][j];
                    b += grid[i][j] * nsum(i, j);
                end
                tot = t;
                mag = (t * 16384) / 4096;
                num = -b * 256 + longint'(field) * t;
                den = 4 * 4096 * 256 + longint'(field) * 64;
                if (den <= 0)
                begin
                    st = 1;
                    ratio = num > 0 ? 32767 : (num < 0 ? -32768 : 0);
                end
                else
                begin
                    q = (num * 4096) / den;
                    ratio = q > 32767 ? 32767 : (q < -32768 ? -32768 : q);
                    st = (ratio != q);
                end
            end
        endcase
        pending.push_back({st, 16'(ratio), 16'(mag), 14'(tot), 18'(delta)});
    endfunction

    function void check_result(logic [63:0] d, logic u);
        logic [64:0] exp_word;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result %h %b", $time, d, u);
            errors++;
            return;
        end
        exp_word = pending.pop_front();
        if (exp_word[17:0] !== d[17:0])
        begin
            $display("%0t: delta_energy exp %h act %h", $time, exp_word[17:0], d[17:0]);
            errors++;
        end
        if (exp_word[31:18] !== d[31:18])
        begin
            $display("%0t: total_spin exp %h act %h", $time, exp_word[31:18], d[31:18]);
            errors++;
        end
        if (exp_word[47:32] !== d[47:32])
        begin
            $display("%0t: magnetisation exp %h act %h", $time, exp_word[47:32], d[47:32]);
            errors++;
        end
        if (exp_word[63:48] !== d[63:48])
        begin
            $display("%0t: energy_ratio exp %h act %h", $time, exp_word[63:48], d[63:48]);
            errors++;
        end
        if (exp_word[64] !== u)
        begin
            $display("%0t: status exp %b act %b", $time, exp_word[64], u);
            errors++;
        end
    endfunction
endclass

module tb;
    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    ising_scoreboard sb;
    int src_idle;
    int sink_idle;
    int hold_cycles;

    ising_grid_energy_evaluator_core u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        clk = 0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    task automatic send_request(ige_pkg::cmd_e_t cmd, logic [5:0] r, logic [5:0] c,
                                logic [1:0] s);
        while ($urandom_range(99) < src_idle)
        begin
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {s, c, r, cmd};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        sb.note_request({s, c, r, cmd});
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random(int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 50)
            begin
                send_request(ige_pkg::CMD_WRITE, 6'($urandom), 6'($urandom), 2'($urandom));
            end
            else if (k < 90)
            begin
                send_request(ige_pkg::CMD_FLIP, 6'($urandom), 6'($urandom), 2'($urandom));
            end
            else if (k < 98)
            begin
                send_request(ige_pkg::CMD_TOTALS, 6'($urandom), 6'($urandom), 2'($urandom));
            end
            else
            begin
                send_request(ige_pkg::CMD_CLEAR, 6'($urandom), 6'($urandom), 2'($urandom));
            end
        end
    endtask

    task automatic write_field(logic [15:0] h);
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20000) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= h;
        @(posedge clk);
        sb.field = h;
        cfg_wr_en <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle);
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    initial
    begin
        #400_000_000;
        $display("** ising_grid_energy_evaluator_core: FAILED **");
        $finish;
    end

    initial
    begin
        sb = new();
        rst_n = 0;
        cfg_wr_en = 0;
        cfg_wr_data = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        m_axis_tready = 0;
        src_idle = 33;
        sink_idle = 83;
        hold_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Extremes, every command, index wrap and the spin pattern that maps to -1.
        send_request(ige_pkg::CMD_TOTALS, 0, 0, 0);
        send_request(ige_pkg::CMD_WRITE, 0, 0, 2'b01);
        send_request(ige_pkg::CMD_WRITE, 63, 0, 2'b01);
        send_request(ige_pkg::CMD_WRITE, 0, 63, 2'b11);
        send_request(ige_pkg::CMD_WRITE, 1, 0, 2'b10);
        send_request(ige_pkg::CMD_WRITE, 0, 1, 2'b01);
        send_request(ige_pkg::CMD_FLIP, 0, 0, 0);
        send_request(ige_pkg::CMD_FLIP, 63, 63, 2'b11);
        send_request(ige_pkg::CMD_TOTALS, 63, 63, 2'b11);
        send_request(ige_pkg::CMD_CLEAR, 0, 0, 0);
        send_request(ige_pkg::CMD_FLIP, 0, 0, 0);
        for (int i = 0; i < 8; i++)
        begin
            send_request(ige_pkg::CMD_WRITE, 6'(i * 9), 6'(i * 7), 2'b01);
        end
        send_request(ige_pkg::CMD_TOTALS, 0, 0, 0);

        hold_cycles = 3000;
        send_random(40);
        send_random(300);

        write_field(16'h7fff);
        send_random(100);
        write_field(16'h8000);
        send_random(100);
        src_idle = 83;
        sink_idle = 33;
        write_field(16'hff00);
        send_random(200);
        write_field(16'hc000);
        send_random(150);
        src_idle = 0;
        sink_idle = 0;
        write_field(16'h0180);
        send_random(300);
        write_field(16'h5a5a);
        send_random(150);
        write_field(16'h0000);
        send_random(150);

        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("** ising_grid_energy_evaluator_core: PASSED **");
        end
        else
        begin
            $display("** ising_grid_energy_evaluator_core: FAILED **");
        end
        $finish;
    end
endmodule
